// ----- rtl/core/fret_efficiency_gradient_top_assert.svh -----
// Assertion macros shared by the FRET efficiency datapath modules.
`ifndef FRET_EFFICIENCY_GRADIENT_TOP_ASSERT_SVH
`define FRET_EFFICIENCY_GRADIENT_TOP_ASSERT_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define FEG_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same, on the usual clk_i / rst_ni pair.
`define FEG_ASSERT(lbl, prop, msg) `FEG_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/core/feg_pkg.sv -----
// Package: widths, constants and types of the FRET efficiency datapath.
`timescale 1ns / 1ps
`default_nettype none

package feg_pkg;

  localparam int unsigned RADIUS_W = 32;
  localparam int unsigned EFF_W    = 17;
  localparam int unsigned GRAD_W   = 32;
  localparam int unsigned V_W      = 32;  // reduced component, Q8.24
  localparam int unsigned V_FRAC   = 24;
  localparam int unsigned SQ_W     = 64;
  localparam int unsigned USUM_W   = 50;
  localparam int unsigned U_W      = 42;  // u below 2^10 in Q.32
  localparam int unsigned UH_W     = 21;
  localparam int unsigned PP_W     = 42;
  localparam int unsigned U2_W     = 52;
  localparam int unsigned U2H_W    = 26;
  localparam int unsigned PU_W     = 47;
  localparam int unsigned U3F_W    = 94;
  localparam int unsigned DEN_W    = 63;
  localparam int unsigned QD_W     = 31;  // quotient width of the den dividers
  localparam int unsigned QW_W     = 52;
  localparam int unsigned Q_W      = 42;
  localparam int unsigned P_W      = 52;
  localparam int unsigned PH_W     = 26;
  localparam int unsigned PV_W     = 58;
  localparam int unsigned H_W      = 64;
  localparam int unsigned N_W      = 43;
  localparam int unsigned NS_W     = 64;

  localparam logic [RADIUS_W-1:0] R0_RESET = 32'd360448;  // 5.5 in Q16.16
  localparam logic [EFF_W-1:0]    EFF_ONE  = 17'd65536;
  localparam logic [GRAD_W-1:0]   GRAD_MIN = 32'h8000_0000;
  localparam logic [GRAD_W-1:0]   GRAD_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic       zero;  // atoms coincide
    logic       kill;  // far pair, result forced to zero
    logic [2:0] neg;   // sign of each difference component
  } feg_flags_t;

endpackage

`default_nettype wire

// ----- rtl/core/feg_if.sv -----
// Valid/ready channel interfaces for atom pairs and efficiency results.
`timescale 1ns / 1ps
`default_nettype none

interface feg_in_if #(
  parameter int unsigned COORD_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] first_z;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;
  logic signed [COORD_WIDTH-1:0] second_z;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
    output ready
  );
endinterface

interface feg_out_if ();
  import feg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [EFF_W-1:0]         efficiency;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic signed [GRAD_W-1:0] grad_z;
  logic                     zero_distance;

  modport source (
    output valid, efficiency, grad_x, grad_y, grad_z, zero_distance,
    input  ready
  );
  modport sink (
    input  valid, efficiency, grad_x, grad_y, grad_z, zero_distance,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/feg_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
`include "fret_efficiency_gradient_top_assert.svh"

module feg_div #(
  parameter int unsigned DVD_W  = 64,
  parameter int unsigned DVS_W  = 32,
  parameter int unsigned QUO_W  = 32,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [DVD_W-1:0]  dvd_i,
  input  logic [DVS_W-1:0]  dvs_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic              ovf_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned HI_W  = DVD_W - QUO_W;
  localparam int unsigned CMP_W = (HI_W > DVS_W) ? HI_W : DVS_W;

  logic [CMP_W-1:0]  hi_ext;
  logic [CMP_W-1:0]  dvs_ext;
  logic              ovf_in;

  logic              vld_q  [QUO_W+1];
  logic              ovf_q  [QUO_W+1];
  logic [DVS_W-1:0]  rem_q  [QUO_W+1];
  logic [QUO_W-1:0]  acc_q  [QUO_W+1];  // dividend bits out the top, quotient bits in
  logic [DVS_W-1:0]  dvs_q  [QUO_W+1];
  logic [SIDE_W-1:0] side_q [QUO_W+1];

  assign hi_ext  = CMP_W'(dvd_i[DVD_W-1:QUO_W]);
  assign dvs_ext = CMP_W'(dvs_i);
  assign ovf_in  = (hi_ext >= dvs_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0]  <= ovf_in;
      rem_q[0]  <= hi_ext[DVS_W-1:0];
      acc_q[0]  <= dvd_i[QUO_W-1:0];
      dvs_q[0]  <= dvs_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;
    logic [DVS_W-1:0] rem_d;

    assign trial = {rem_q[k-1], acc_q[k-1][QUO_W-1]};
    assign diff  = trial - {1'b0, dvs_q[k-1]};
    assign ge    = (trial >= {1'b0, dvs_q[k-1]});
    assign rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ovf_q[k]  <= ovf_q[k-1];
        rem_q[k]  <= rem_d;
        acc_q[k]  <= {acc_q[k-1][QUO_W-2:0], ge};
        dvs_q[k]  <= dvs_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign vld_o  = vld_q[QUO_W];
  assign quo_o  = acc_q[QUO_W];
  assign ovf_o  = ovf_q[QUO_W];
  assign side_o = side_q[QUO_W];

  // without overflow the final remainder must be below the divisor
  `FEG_ASSERT(a_div_rem, vld_q[QUO_W] && !ovf_q[QUO_W] |-> rem_q[QUO_W] < dvs_q[QUO_W], "divider remainder not reduced")

endmodule

`default_nettype wire

// ----- rtl/core/feg_poly.sv -----
// Squared reduced distance u, its cube and the denominator 1 + u^3.
`timescale 1ns / 1ps
`default_nettype none

module feg_poly (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             vld_i,
  input  logic [2:0][feg_pkg::V_W-1:0]     v_i,
  input  feg_pkg::feg_flags_t              flags_i,
  output logic                             vld_o,
  output logic [feg_pkg::U_W-1:0]          u_o,
  output logic [feg_pkg::DEN_W-1:0]        den_o,
  output logic [2:0][feg_pkg::V_W-1:0]     v_o,
  output feg_pkg::feg_flags_t              flags_o
);
  import feg_pkg::*;

  localparam int unsigned NSTG = 6;

  logic [NSTG:1]          vld_q;
  logic [2:0][V_W-1:0]    v_q   [1:NSTG];
  feg_flags_t             flg_q [1:NSTG];

  logic [2:0][SQ_W-1:0]   sq_q;
  logic [USUM_W-1:0]      usum_d;
  logic [USUM_W-1:0]      usum_q;
  logic                   far_d;
  logic [U_W-1:0]         u3_q;
  logic [U_W-1:0]         u4_q;
  logic [U_W-1:0]         u5_q;
  logic [PP_W-1:0]        hh_q;
  logic [PP_W-1:0]        hl_q;
  logic [PP_W-1:0]        ll_q;
  logic [2*U_W-1:0]       u2_full;
  logic [U2_W-1:0]        u2_q;
  logic [3:0][PU_W-1:0]   pr_q;
  logic [U3F_W-1:0]       u3_full;
  logic [DEN_W-1:0]       den_d;
  logic [DEN_W-1:0]       den_q;

  assign usum_d = USUM_W'(sq_q[0][SQ_W-1:16]) + USUM_W'(sq_q[1][SQ_W-1:16])
                + USUM_W'(sq_q[2][SQ_W-1:16]);
  assign far_d  = |usum_q[USUM_W-1:U_W];

  assign u2_full = ((2*U_W)'(hh_q) << 42) + ((2*U_W)'(hl_q) << 22) + (2*U_W)'(ll_q);
  assign u3_full = (U3F_W'(pr_q[3]) << 47) + (U3F_W'(pr_q[2]) << 26)
                 + (U3F_W'(pr_q[1]) << 21) + U3F_W'(pr_q[0]);
  assign den_d   = (DEN_W'(1) << 32) + DEN_W'(u3_full[U3F_W-1:32]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-1:1], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q[1]   <= v_i;
      flg_q[1] <= flags_i;
      for (int k = 2; k <= NSTG; k++) begin
        v_q[k] <= v_q[k-1];
      end
      flg_q[2] <= flg_q[1];
      flg_q[3] <= '{zero: flg_q[2].zero, kill: flg_q[2].kill | far_d, neg: flg_q[2].neg};
      for (int k = 4; k <= NSTG; k++) begin
        flg_q[k] <= flg_q[k-1];
      end
      // squares of the reduced components
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= v_i[i] * v_i[i];
      end
      usum_q <= usum_d;
      // u*u in 21-bit halves
      u3_q <= usum_q[U_W-1:0];
      hh_q <= usum_q[U_W-1:UH_W] * usum_q[U_W-1:UH_W];
      hl_q <= usum_q[U_W-1:UH_W] * usum_q[UH_W-1:0];
      ll_q <= usum_q[UH_W-1:0] * usum_q[UH_W-1:0];
      u4_q <= u3_q;
      u2_q <= u2_full[2*U_W-1:32];
      // u2*u in halves
      u5_q    <= u4_q;
      pr_q[3] <= u2_q[U2_W-1:U2H_W] * u4_q[U_W-1:UH_W];
      pr_q[2] <= u2_q[U2_W-1:U2H_W] * u4_q[UH_W-1:0];
      pr_q[1] <= u2_q[U2H_W-1:0] * u4_q[U_W-1:UH_W];
      pr_q[0] <= u2_q[U2H_W-1:0] * u4_q[UH_W-1:0];
      den_q   <= den_d;
    end
  end

  // u leaves with the stage-5 copy delayed once more to line up with den
  logic [U_W-1:0] u6_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u6_q <= u5_q;
    end
  end

  assign vld_o   = vld_q[NSTG];
  assign u_o     = u6_q;
  assign den_o   = den_q;
  assign v_o     = v_q[NSTG];
  assign flags_o = flg_q[NSTG];

endmodule

`default_nettype wire

// ----- rtl/core/feg_scale.sv -----
// Gradient numerator: q = u*w, p = q^2, n = 6*p*v, scaled to the coordinate format.
`timescale 1ns / 1ps
`default_nettype none

module feg_scale #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned SIDE_W    = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           vld_i,
  input  logic [feg_pkg::U_W-1:0]        u_i,
  input  logic [feg_pkg::QD_W-1:0]       w_i,
  input  logic [2:0][feg_pkg::V_W-1:0]   v_i,
  input  logic [SIDE_W-1:0]              side_i,
  output logic                           vld_o,
  output logic [2:0][feg_pkg::NS_W-1:0]  ns_o,
  output logic [SIDE_W-1:0]              side_o
);
  import feg_pkg::*;

  localparam int unsigned NSTG = 7;
  localparam int          SH   = 2 * FRAC_BITS - 32;
  localparam int unsigned SHL  = (SH > 0) ? SH : 0;
  localparam int unsigned SHR  = (SH < 0) ? -SH : 0;

  logic [NSTG:1]         vld_q;
  logic [SIDE_W-1:0]     side_q [1:NSTG];
  logic [2:0][V_W-1:0]   v_q    [1:4];

  logic [QW_W-1:0]       puh_q;
  logic [QW_W-1:0]       pul_q;
  logic [QW_W+20:0]      q_full;
  logic [Q_W-1:0]        q_q;
  logic [PP_W-1:0]       hh_q;
  logic [PP_W-1:0]       hl_q;
  logic [PP_W-1:0]       ll_q;
  logic [2*Q_W-1:0]      p_full;
  logic [P_W-1:0]        p_q;
  logic [2:0][PV_W-1:0]  mh_q;
  logic [2:0][PV_W-1:0]  ml_q;
  logic [2:0][H_W-1:0]   h_q;
  logic [2:0][H_W+2:0]   six_h;
  logic [2:0][NS_W-1:0]  ns_d;
  logic [2:0][NS_W-1:0]  ns_q;

  assign q_full = ((QW_W+21)'(puh_q) << 21) + (QW_W+21)'(pul_q);
  assign p_full = ((2*Q_W)'(hh_q) << 42) + ((2*Q_W)'(hl_q) << 22) + (2*Q_W)'(ll_q);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      six_h[i] = {h_q[i], 2'b00} + {1'b0, h_q[i], 1'b0};
      ns_d[i]  = (NS_W'(six_h[i][H_W+2:V_FRAC]) << SHL) >> SHR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-1:1], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[1] <= side_i;
      for (int k = 2; k <= NSTG; k++) begin
        side_q[k] <= side_q[k-1];
      end
      v_q[1] <= v_i;
      for (int k = 2; k <= 4; k++) begin
        v_q[k] <= v_q[k-1];
      end
      // u*w in halves of u
      puh_q <= u_i[U_W-1:UH_W] * w_i;
      pul_q <= u_i[UH_W-1:0] * w_i;
      q_q   <= q_full[Q_W+29:30];
      // q*q in halves
      hh_q  <= q_q[Q_W-1:UH_W] * q_q[Q_W-1:UH_W];
      hl_q  <= q_q[Q_W-1:UH_W] * q_q[UH_W-1:0];
      ll_q  <= q_q[UH_W-1:0] * q_q[UH_W-1:0];
      p_q   <= p_full[2*Q_W-1:32];
      // p*v, low 64 bits kept
      for (int i = 0; i < 3; i++) begin
        mh_q[i] <= p_q[P_W-1:PH_W] * v_q[4][i];
        ml_q[i] <= p_q[PH_W-1:0] * v_q[4][i];
        h_q[i]  <= (H_W'(mh_q[i]) << PH_W) + H_W'(ml_q[i]);
      end
      ns_q <= ns_d;
    end
  end

  assign vld_o  = vld_q[NSTG];
  assign ns_o   = ns_q;
  assign side_o = side_q[NSTG];

endmodule

`default_nettype wire

// ----- rtl/core/fret_efficiency_gradient_top.sv -----
// Top level: FRET efficiency and second-atom gradient of an atom pair.
// Throughput: one pair per cycle while the pipeline is not held; every stage is a register slice under one enable.
// The pipeline keeps moving while a result waits, as long as its last stage is empty.
// Reset: asynchronous, active low; clears all valid bits and loads R0 = 5.5 (Q16.16).
`timescale 1ns / 1ps
`default_nettype none
`include "fret_efficiency_gradient_top_assert.svh"

module fret_efficiency_gradient_top #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [feg_pkg::RADIUS_W-1:0]   cfg_wdata_i,
  feg_in_if.sink                         in_i,
  feg_out_if.source                      out_o
);
  import feg_pkg::*;

  localparam int unsigned FLG_W = $bits(feg_flags_t);

  // Forster radius; the user must write it only while the pipeline is idle, the block does not enforce this
  logic [RADIUS_W-1:0] r0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_q <= R0_RESET;
    end else if (cfg_we_i) begin
      r0_q <= cfg_wdata_i;
    end
  end

  // Global advance: held only when the last stage has an item and the
  // output register holds a result nobody takes.
  logic en;
  logic last_vld;
  logic out_vld_q;

  assign en         = !out_vld_q || out_o.ready || !last_vld;
  assign in_i.ready = en;

  // ---------------------------------------------------------------
  // Stage A: difference vector, magnitude, sign, coincidence
  // ---------------------------------------------------------------
  logic [2:0][COORD_WIDTH-1:0] fst;
  logic [2:0][COORD_WIDTH-1:0] snd;
  logic [2:0][COORD_WIDTH:0]   diff;
  logic [2:0][COORD_WIDTH-1:0] mag_d;
  logic                        a_vld_q;
  logic [2:0][COORD_WIDTH-1:0] mag_q;
  logic [2:0]                  neg_q;
  logic                        zero_q;

  assign fst = {in_i.first_z, in_i.first_y, in_i.first_x};
  assign snd = {in_i.second_z, in_i.second_y, in_i.second_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]  = {snd[i][COORD_WIDTH-1], snd[i]} - {fst[i][COORD_WIDTH-1], fst[i]};
      mag_d[i] = diff[i][COORD_WIDTH] ? COORD_WIDTH'(-diff[i]) : diff[i][COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q  <= mag_d;
      neg_q  <= {diff[2][COORD_WIDTH], diff[1][COORD_WIDTH], diff[0][COORD_WIDTH]};
      zero_q <= (mag_d == '0);
    end
  end

  // ---------------------------------------------------------------
  // Reduced components v = |d| * 2^24 / R0; overflow marks a far pair
  // ---------------------------------------------------------------
  logic              v_vld;
  logic [2:0][V_W-1:0] v_quo;
  logic [2:0]        v_ovf;
  logic [1:0]        v_side0;
  logic              v_side1;
  logic              v_side2;

  feg_div #(.DVD_W(COORD_WIDTH + V_FRAC), .DVS_W(RADIUS_W), .QUO_W(V_W), .SIDE_W(2))
  u_div_v0 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(a_vld_q),
    .dvd_i({mag_q[0], V_FRAC'(0)}), .dvs_i(r0_q), .side_i({zero_q, neg_q[0]}),
    .vld_o(v_vld), .quo_o(v_quo[0]), .ovf_o(v_ovf[0]), .side_o(v_side0)
  );

  feg_div #(.DVD_W(COORD_WIDTH + V_FRAC), .DVS_W(RADIUS_W), .QUO_W(V_W), .SIDE_W(1))
  u_div_v1 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(a_vld_q),
    .dvd_i({mag_q[1], V_FRAC'(0)}), .dvs_i(r0_q), .side_i(neg_q[1]),
    .vld_o(), .quo_o(v_quo[1]), .ovf_o(v_ovf[1]), .side_o(v_side1)
  );

  feg_div #(.DVD_W(COORD_WIDTH + V_FRAC), .DVS_W(RADIUS_W), .QUO_W(V_W), .SIDE_W(1))
  u_div_v2 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(a_vld_q),
    .dvd_i({mag_q[2], V_FRAC'(0)}), .dvs_i(r0_q), .side_i(neg_q[2]),
    .vld_o(), .quo_o(v_quo[2]), .ovf_o(v_ovf[2]), .side_o(v_side2)
  );

  feg_flags_t v_flags;
  assign v_flags.zero = v_side0[1];
  assign v_flags.kill = |v_ovf;
  assign v_flags.neg  = {v_side2, v_side1, v_side0[0]};

  // ---------------------------------------------------------------
  // u, u^3 and den = 1 + u^3
  // ---------------------------------------------------------------
  logic                p_vld;
  logic [U_W-1:0]      p_u;
  logic [DEN_W-1:0]    p_den;
  logic [2:0][V_W-1:0] p_v;
  feg_flags_t          p_flags;

  feg_poly u_poly (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v_vld), .v_i(v_quo), .flags_i(v_flags),
    .vld_o(p_vld), .u_o(p_u), .den_o(p_den), .v_o(p_v), .flags_o(p_flags)
  );

  // ---------------------------------------------------------------
  // w = 2^62 / den and E = round(2^48 / den), side by side
  // ---------------------------------------------------------------
  localparam int unsigned WS_W = U_W + 3 * V_W;

  logic              w_vld;
  logic [QD_W-1:0]   w_quo;
  logic [WS_W-1:0]   w_side;
  logic [QD_W-1:0]   e_quo;
  logic [FLG_W-1:0]  e_side;
  logic [DEN_W-1:0]  e_dvd;

  assign e_dvd = (DEN_W'(1) << 48) + (p_den >> 1);

  feg_div #(.DVD_W(DEN_W), .DVS_W(DEN_W), .QUO_W(QD_W), .SIDE_W(WS_W)) u_div_w (
    .clk_i, .rst_ni, .en_i(en), .vld_i(p_vld),
    .dvd_i(DEN_W'(1) << 62), .dvs_i(p_den), .side_i({p_u, p_v}),
    .vld_o(w_vld), .quo_o(w_quo), .ovf_o(), .side_o(w_side)
  );

  feg_div #(.DVD_W(DEN_W), .DVS_W(DEN_W), .QUO_W(QD_W), .SIDE_W(FLG_W)) u_div_e (
    .clk_i, .rst_ni, .en_i(en), .vld_i(p_vld),
    .dvd_i(e_dvd), .dvs_i(p_den), .side_i(p_flags),
    .vld_o(), .quo_o(e_quo), .ovf_o(), .side_o(e_side)
  );

  // ---------------------------------------------------------------
  // Gradient numerator n_i, then magnitude n_i / R0
  // ---------------------------------------------------------------
  localparam int unsigned SS_W = EFF_W + FLG_W;

  logic                 s_vld;
  logic [2:0][NS_W-1:0] s_ns;
  logic [SS_W-1:0]      s_side;
  feg_flags_t           s_flags;

  feg_scale #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SS_W)) u_scale (
    .clk_i, .rst_ni, .en_i(en), .vld_i(w_vld),
    .u_i(w_side[WS_W-1:3*V_W]), .w_i(w_quo), .v_i(w_side[3*V_W-1:0]),
    .side_i({e_quo[EFF_W-1:0], e_side}),
    .vld_o(s_vld), .ns_o(s_ns), .side_o(s_side)
  );

  assign s_flags = s_side[FLG_W-1:0];

  logic [2:0][GRAD_W-1:0] g_quo;
  logic [2:0]             g_ovf;
  logic [SS_W-1:0]        g_side0;
  logic                   g_neg1;
  logic                   g_neg2;

  feg_div #(.DVD_W(NS_W), .DVS_W(RADIUS_W), .QUO_W(GRAD_W), .SIDE_W(SS_W)) u_div_g0 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s_vld),
    .dvd_i(s_ns[0]), .dvs_i(r0_q), .side_i(s_side),
    .vld_o(last_vld), .quo_o(g_quo[0]), .ovf_o(g_ovf[0]), .side_o(g_side0)
  );

  feg_div #(.DVD_W(NS_W), .DVS_W(RADIUS_W), .QUO_W(GRAD_W), .SIDE_W(1)) u_div_g1 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s_vld),
    .dvd_i(s_ns[1]), .dvs_i(r0_q), .side_i(s_flags.neg[1]),
    .vld_o(), .quo_o(g_quo[1]), .ovf_o(g_ovf[1]), .side_o(g_neg1)
  );

  feg_div #(.DVD_W(NS_W), .DVS_W(RADIUS_W), .QUO_W(GRAD_W), .SIDE_W(1)) u_div_g2 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s_vld),
    .dvd_i(s_ns[2]), .dvs_i(r0_q), .side_i(s_flags.neg[2]),
    .vld_o(), .quo_o(g_quo[2]), .ovf_o(g_ovf[2]), .side_o(g_neg2)
  );

  // ---------------------------------------------------------------
  // Sign, saturation, special cases, output register
  // ---------------------------------------------------------------
  feg_flags_t             f_flags;
  logic [EFF_W-1:0]       f_eff;
  logic [2:0]             f_neg;
  logic [2:0][GRAD_W-1:0] grad_d;
  logic [EFF_W-1:0]       eff_d;

  assign f_flags = g_side0[FLG_W-1:0];
  assign f_eff   = g_side0[SS_W-1:FLG_W];
  assign f_neg   = {g_neg2, g_neg1, f_flags.neg[0]};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // gradient points against d
      if (!f_neg[i]) begin
        if (g_ovf[i] || (g_quo[i] > GRAD_MIN)) begin
          grad_d[i] = GRAD_MIN;
        end else begin
          grad_d[i] = -g_quo[i];
        end
      end else begin
        if (g_ovf[i] || g_quo[i][GRAD_W-1]) begin
          grad_d[i] = GRAD_MAX;
        end else begin
          grad_d[i] = g_quo[i];
        end
      end
      if (f_flags.zero || f_flags.kill) begin
        grad_d[i] = '0;
      end
    end
    if (f_flags.zero) begin
      eff_d = EFF_ONE;
    end else if (f_flags.kill) begin
      eff_d = '0;
    end else begin
      eff_d = f_eff;
    end
  end

  logic [EFF_W-1:0]       eff_q;
  logic [2:0][GRAD_W-1:0] grad_q;
  logic                   zero_o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en && last_vld) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && last_vld) begin
      eff_q    <= eff_d;
      grad_q   <= grad_d;
      zero_o_q <= f_flags.zero;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.efficiency    = eff_q;
  assign out_o.grad_x        = grad_q[0];
  assign out_o.grad_y        = grad_q[1];
  assign out_o.grad_z        = grad_q[2];
  assign out_o.zero_distance = zero_o_q;

  `FEG_ASSERT(a_zero_result, out_vld_q && zero_o_q |-> eff_q == EFF_ONE && grad_q == '0, "coincident pair gave nonzero gradient or efficiency below one")
  `FEG_ASSERT(a_eff_range, out_vld_q |-> eff_q <= EFF_ONE, "efficiency above one")
  `FEG_ASSERT(a_out_hold, out_vld_q && !out_o.ready |=> out_vld_q && $stable(eff_q), "result lost")

endmodule

`default_nettype wire
